>>> rtl/adaptive_latency_request_controller_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive latency request controller.
// Each macro expands to one labeled concurrent assertion.
// The assertion is clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_LATENCY_REQUEST_CONTROLLER_ASSERT_SVH
`define ADAPTIVE_LATENCY_REQUEST_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ALRC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ALRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/alrc_pkg.sv
// ----------------------------------------------------------------------------
// alrc_pkg
// Shared constants, codes and types of the adaptive latency request
// controller: ring geometry, field layout of the stream words, and the
// command and status structs between the controller and the ring engine.
// ----------------------------------------------------------------------------
`default_nettype none

package alrc_pkg;

  // Busy ring geometry. The window must be a power of two.
  localparam int WINDOW_MS = 1024;
  localparam int WIN_AW    = $clog2(WINDOW_MS);
  localparam int CNT_W     = WIN_AW + 1;

  // Field widths fixed by the word formats.
  localparam int REQ_W    = 8;
  localparam int BUSY_W   = 11;
  localparam int SWAIT_W  = 31;
  localparam int STIME_W  = 17;
  localparam int PERIOD_W = 16;
  localparam int THR_W    = 11;
  localparam int PCT_W    = 7;
  localparam int RATE_W   = 8;
  localparam int CFG_W    = 16;
  localparam int CFG_IX_W = 3;

  // Sampling starts at this turn.
  localparam logic [31:0] SAMPLE_START_TURN = 32'd50;
  localparam logic [SWAIT_W-1:0] WAIT_SAT = '1;
  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;
  localparam int CMP_W = SWAIT_W + PCT_W;

  // Hold-off turns are period * rate / 1000, done as a reciprocal multiply.
  // For products below 2^24 the rounded-up reciprocal gives the exact floor.
  localparam int          HOLD_P_W   = PERIOD_W + RATE_W;
  localparam int          HOLD_SHIFT = 34;
  localparam longint      HOLD_DIV   = 1000;
  localparam int          HOLD_R_W   = 25;
  localparam logic [HOLD_R_W-1:0] HOLD_RECIP =
    HOLD_R_W'(((64'd1 << HOLD_SHIFT) + HOLD_DIV - 1) / HOLD_DIV);
  localparam int          HOLD_M_W   = HOLD_P_W + HOLD_R_W;
  localparam int          HOLD_Q_W   = 15;

  // Reset values of the configuration registers.
  localparam logic [PERIOD_W-1:0] DIRECT_RST = 16'd2000;
  localparam logic [PERIOD_W-1:0] RELAY_RST  = 16'd4000;
  localparam logic [THR_W-1:0]    THR_RST    = 11'd100;
  localparam logic [PCT_W-1:0]    PCT_RST    = 7'd5;
  localparam logic [RATE_W-1:0]   RATE_RST   = 8'd20;
  localparam logic [REQ_W-1:0]    MAXREQ_RST = 8'd10;

  // Input word layout (tdata), lowest bit first.
  localparam int IN_NOW_LSB    = 0;
  localparam int IN_WAIT_LSB   = 32;
  localparam int IN_TURN_LSB   = 48;
  localparam int IN_LINK_BIT   = 80;
  localparam int IN_PAUSE_BIT  = 81;
  localparam int IN_SKIP_BIT   = 82;
  localparam int IN_PEERS_LSB  = 83;
  localparam int IN_NEWREQ_LSB = 87;
  localparam int IN_DATA_W     = 96;
  localparam int FUNC_W        = 2;

  // Output word layout (tdata), lowest bit first.
  localparam int OUT_REQ_LSB   = 0;
  localparam int OUT_BUSY_LSB  = 8;
  localparam int OUT_WAIT_LSB  = 19;
  localparam int OUT_TIME_LSB  = 50;
  localparam int OUT_CHG_LSB   = 67;
  localparam int OUT_USED_W    = 69;
  localparam int OUT_DATA_W    = 72;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK = 2'd0,
    FN_WAIT = 2'd1,
    FN_LOAD = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    CHG_NONE  = 2'd0,
    CHG_RAISE = 2'd1,
    CHG_LOWER = 2'd2
  } chg_t;

  typedef enum logic [CFG_IX_W-1:0] {
    CFG_PERIOD_DIRECT = 3'd0,
    CFG_PERIOD_RELAY  = 3'd1,
    CFG_RAISE_THR     = 3'd2,
    CFG_LOWER_PCT     = 3'd3,
    CFG_TURN_RATE     = 3'd4,
    CFG_MAX_REQUEST   = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    RING_CLEAR = 2'd0,
    RING_AGE   = 2'd1,
    RING_MARK  = 2'd2
  } ring_op_t;

  typedef struct packed {
    logic              start;
    ring_op_t          op;
    logic [WIN_AW-1:0] addr;
    logic [CNT_W-1:0]  len;
  } ring_cmd_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] count;
  } ring_stat_t;

endpackage

`default_nettype wire

>>> rtl/adaptive_latency_request_controller.sv
// ----------------------------------------------------------------------------
// adaptive_latency_request_controller: one word in, one word out, sequential.
// Throughput: one word at a time, bound by the slot-by-slot walk over the busy map.
// Reset: synchronous; a clearing pass of the map follows, with s_axis_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

// The controller keeps a buffering request in turns. Busy milliseconds are
// marked in a one-bit map of WINDOW_MS entries held in a synchronous RAM.
// The ring engine walks that RAM one slot per cycle, reading a slot and
// writing it back in the next cycle, and keeps the busy count. All other
// state sits in registers beside a short arithmetic pipeline:
//   prep   - time differences, period select, hold-off product, wait sum
//   sum    - new sample time, hold-off reciprocal multiply
//   mult   - waiting share products for the decrease decision
//   decide - state update and the first ring command
// Configuration registers are written at any time through cfg_we; the
// active period only follows the period registers at the next live tick.
module adaptive_latency_request_controller import alrc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // Input word.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: now_ms[31:0], wait_ms[47:32], turn_number[79:48], link_active[80],
  // paused[81], startup_skip[82], remote_peers[86:83], new_request[94:87].
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: func[1:0].
  input  logic [FUNC_W-1:0]     s_axis_tuser,
  // Result word.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: lag_request[7:0], busy_ms[18:8], lower_wait_ms[49:19],
  // lower_sample_ms[66:50], change[68:67].
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  typedef enum logic [11:0] {
    ST_INIT       = 12'b0000_0000_0001,
    ST_WAIT_INIT  = 12'b0000_0000_0010,
    ST_IDLE       = 12'b0000_0000_0100,
    ST_PREP       = 12'b0000_0000_1000,
    ST_SUM        = 12'b0000_0001_0000,
    ST_MULT       = 12'b0000_0010_0000,
    ST_DECIDE     = 12'b0000_0100_0000,
    ST_WAIT_MARK  = 12'b0000_1000_0000,
    ST_WAIT_RAISE = 12'b0001_0000_0000,
    ST_RAISE      = 12'b0010_0000_0000,
    ST_WAIT_DONE  = 12'b0100_0000_0000,
    ST_DONE       = 12'b1000_0000_0000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [PERIOD_W-1:0] period_direct;
  logic [PERIOD_W-1:0] period_relay;
  logic [THR_W-1:0]    raise_thr;
  logic [PCT_W-1:0]    lower_pct;
  logic [RATE_W-1:0]   turn_rate;
  logic [REQ_W-1:0]    max_request;

  // Architectural state outside the busy map.
  logic [31:0]         window_last;
  logic [31:0]         sample_last;
  logic [STIME_W-1:0]  sample_time;
  logic [SWAIT_W-1:0]  sample_wait;
  logic [REQ_W-1:0]    request;
  logic [31:0]         holdoff;
  logic [PERIOD_W-1:0] active_period;
  logic [1:0]          change;

  // Latched input word.
  logic [FUNC_W-1:0]   func_r;
  logic [31:0]         now_r;
  logic [15:0]         wait_r;
  logic [31:0]         turn_r;
  logic                link_r;
  logic                paused_r;
  logic                skip_r;
  logic [3:0]          peers_r;
  logic [REQ_W-1:0]    newreq_r;

  // Pipeline work registers.
  logic [PERIOD_W-1:0] period_r;
  logic [PERIOD_W-1:0] s_clip;
  logic                age_all;
  logic [CNT_W-1:0]    age_len;
  logic [CNT_W-1:0]    mark_len;
  logic [HOLD_P_W-1:0] hold_prod;
  logic [HOLD_Q_W-1:0] hold_q;
  logic [SWAIT_W-1:0]  wait_new;
  logic                elig_tick;
  logic                elig_wait;
  logic [STIME_W-1:0]  st_new;
  logic                full_r;
  logic [CMP_W-1:0]    lhs;
  logic [CMP_W-1:0]    rhs;

  // Result register.
  logic                out_valid;
  logic [REQ_W-1:0]    out_req;
  logic [BUSY_W-1:0]   out_busy;
  logic [SWAIT_W-1:0]  out_wait;
  logic [STIME_W-1:0]  out_time;
  logic [1:0]          out_chg;

  ring_cmd_t           ring_cmd;
  ring_stat_t          ring_stat;

  logic [PERIOD_W-1:0] period_sel;
  logic [31:0]         s_diff;
  logic [31:0]         elapsed;
  logic [31:0]         wait_sum;
  logic [HOLD_M_W-1:0] hold_mul;
  logic                dec_ok;
  logic                raise_ok;
  logic                out_free;

  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = !out_valid || m_axis_tready;

  assign period_sel = (peers_r > 4'd1) ? period_relay : period_direct;
  assign s_diff     = now_r - sample_last;
  assign elapsed    = now_r - window_last;
  assign wait_sum   = 32'(sample_wait) + 32'(wait_r);
  assign hold_mul   = HOLD_M_W'(hold_prod) * HOLD_M_W'(HOLD_RECIP);

  // A full sample with a small enough waiting share lowers the request.
  assign dec_ok = (func_r == FN_TICK) && link_r && elig_tick && full_r &&
                  (lhs <= rhs) && (request != '0);

  // Enough busy milliseconds, room below the maximum and the hold-off past.
  assign raise_ok = (32'(ring_stat.count) >= 32'(raise_thr)) &&
                    (request < max_request) && (turn_r >= holdoff);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      period_direct <= DIRECT_RST;
      period_relay  <= RELAY_RST;
      raise_thr     <= THR_RST;
      lower_pct     <= PCT_RST;
      turn_rate     <= RATE_RST;
      max_request   <= MAXREQ_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PERIOD_DIRECT: period_direct <= cfg_data;
        CFG_PERIOD_RELAY:  period_relay  <= cfg_data;
        CFG_RAISE_THR:     raise_thr     <= cfg_data[THR_W-1:0];
        CFG_LOWER_PCT:     lower_pct     <= cfg_data[PCT_W-1:0];
        CFG_TURN_RATE:     turn_rate     <= cfg_data[RATE_W-1:0];
        CFG_MAX_REQUEST:   max_request   <= cfg_data[REQ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Ring commands. A tick that lowers the request, or that finds a gap of a
  // whole window, sweeps the map instead of aging it slot by slot.
  always_comb begin
    ring_cmd       = '0;
    ring_cmd.op    = RING_CLEAR;
    ring_cmd.len   = CNT_W'(WINDOW_MS);
    unique case (state)
      ST_INIT: begin
        ring_cmd.start = 1'b1;
      end
      ST_DECIDE: begin
        ring_cmd.addr = window_last[WIN_AW-1:0] + 1'b1;
        if (func_r == FN_TICK && link_r) begin
          ring_cmd.start = 1'b1;
          if (!dec_ok && !age_all) begin
            ring_cmd.op  = RING_AGE;
            ring_cmd.len = age_len;
          end
        end else if (func_r == FN_WAIT && elig_wait) begin
          ring_cmd.start = 1'b1;
          if (!age_all) begin
            ring_cmd.op  = RING_AGE;
            ring_cmd.len = age_len;
          end
        end else if (func_r == FN_LOAD) begin
          ring_cmd.start = 1'b1;
        end
      end
      ST_WAIT_MARK: begin
        ring_cmd.start = !ring_stat.busy;
        ring_cmd.op    = RING_MARK;
        ring_cmd.addr  = now_r[WIN_AW-1:0];
        ring_cmd.len   = mark_len;
      end
      ST_RAISE: begin
        ring_cmd.start = raise_ok;
      end
      default: begin
        ring_cmd.start = 1'b0;
      end
    endcase
  end

  alrc_ring u_ring (
    .clk  (clk),
    .rst  (rst),
    .cmd  (ring_cmd),
    .stat (ring_stat)
  );

  // Sequencer and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_INIT;
      out_valid     <= 1'b0;
      window_last   <= '0;
      sample_last   <= '0;
      sample_time   <= '0;
      sample_wait   <= '0;
      request       <= '0;
      holdoff       <= '0;
      active_period <= DIRECT_RST;
      change        <= CHG_NONE;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_INIT: begin
          state <= ST_WAIT_INIT;
        end
        ST_WAIT_INIT: begin
          if (!ring_stat.busy) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            change <= CHG_NONE;
            state  <= ST_PREP;
          end
        end
        ST_PREP: begin
          state <= ST_SUM;
        end
        ST_SUM: begin
          state <= ST_MULT;
        end
        ST_MULT: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (func_r == FN_TICK && link_r) begin
            active_period <= period_r;
            sample_last   <= now_r;
            window_last   <= now_r;
            if (dec_ok) begin
              request     <= request - 1'b1;
              holdoff     <= '0;
              sample_time <= '0;
              sample_wait <= '0;
              change      <= CHG_LOWER;
            end else if (elig_tick && full_r) begin
              sample_time <= '0;
              sample_wait <= '0;
            end else begin
              sample_time <= st_new;
            end
            state <= ST_WAIT_DONE;
          end else if (func_r == FN_WAIT && elig_wait) begin
            sample_wait <= wait_new;
            window_last <= now_r;
            state       <= ST_WAIT_MARK;
          end else if (func_r == FN_LOAD) begin
            sample_time <= '0;
            sample_wait <= '0;
            sample_last <= now_r;
            window_last <= now_r;
            request     <= newreq_r;
            holdoff     <= '0;
            state       <= ST_WAIT_DONE;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_WAIT_MARK: begin
          if (!ring_stat.busy) begin
            state <= ST_WAIT_RAISE;
          end
        end
        ST_WAIT_RAISE: begin
          if (!ring_stat.busy) begin
            state <= ST_RAISE;
          end
        end
        ST_RAISE: begin
          if (raise_ok) begin
            request     <= request + 1'b1;
            holdoff     <= turn_r + 32'(hold_q);
            sample_time <= '0;
            sample_wait <= '0;
            sample_last <= now_r;
            window_last <= now_r;
            change      <= CHG_RAISE;
            state       <= ST_WAIT_DONE;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_WAIT_DONE: begin
          if (!ring_stat.busy) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Input latch and arithmetic pipeline.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_axis_tvalid) begin
      func_r   <= s_axis_tuser;
      now_r    <= s_axis_tdata[IN_NOW_LSB +: 32];
      wait_r   <= s_axis_tdata[IN_WAIT_LSB +: 16];
      turn_r   <= s_axis_tdata[IN_TURN_LSB +: 32];
      link_r   <= s_axis_tdata[IN_LINK_BIT];
      paused_r <= s_axis_tdata[IN_PAUSE_BIT];
      skip_r   <= s_axis_tdata[IN_SKIP_BIT];
      peers_r  <= s_axis_tdata[IN_PEERS_LSB +: 4];
      newreq_r <= s_axis_tdata[IN_NEWREQ_LSB +: REQ_W];
    end
    if (state == ST_PREP) begin
      period_r  <= period_sel;
      s_clip    <= (s_diff > 32'(period_sel)) ? period_sel : s_diff[PERIOD_W-1:0];
      age_all   <= (elapsed >= 32'(WINDOW_MS));
      age_len   <= CNT_W'(elapsed[WIN_AW-1:0]);
      mark_len  <= (32'(wait_r) > 32'(WINDOW_MS)) ? CNT_W'(WINDOW_MS) : CNT_W'(wait_r);
      hold_prod <= HOLD_P_W'(active_period) * HOLD_P_W'(turn_rate);
      wait_new  <= (wait_sum > 32'(WAIT_SAT)) ? WAIT_SAT : wait_sum[SWAIT_W-1:0];
      elig_tick <= !paused_r && !skip_r && (turn_r >= SAMPLE_START_TURN);
      elig_wait <= link_r && !paused_r && (turn_r >= SAMPLE_START_TURN);
    end
    if (state == ST_SUM) begin
      st_new <= elig_tick ? STIME_W'(sample_time + STIME_W'(s_clip)) : sample_time;
      hold_q <= HOLD_Q_W'(hold_mul >> HOLD_SHIFT);
    end
    if (state == ST_MULT) begin
      full_r <= (st_new >= STIME_W'(period_r));
      lhs    <= CMP_W'(sample_wait) * CMP_W'(PCT_SCALE);
      rhs    <= CMP_W'(lower_pct) * CMP_W'(st_new);
    end
    if (state == ST_DONE && out_free) begin
      out_req  <= (func_r == FN_TICK && !link_r) ? '0 : request;
      out_busy <= BUSY_W'(ring_stat.count);
      out_wait <= sample_wait;
      out_time <= sample_time;
      out_chg  <= change;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_DATA_W - OUT_USED_W)'(0), out_chg, out_time, out_wait,
                          out_busy, out_req};

endmodule

`default_nettype wire

>>> rtl/alrc_map_ram.sv
// ----------------------------------------------------------------------------
// alrc_map_ram
// One-bit-wide busy map memory, one entry per millisecond slot, with one
// write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module alrc_map_ram import alrc_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [WIN_AW-1:0] waddr,
  input  logic              wdata,
  input  logic              re,
  input  logic [WIN_AW-1:0] raddr,
  output logic              rdata
);

  logic mem [WINDOW_MS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/alrc_ring.sv
// ----------------------------------------------------------------------------
// alrc_ring
// Busy ring engine. Sweeps the map clear, ages out a run of slots, or marks
// a run of slots backwards, keeping the count of marked slots up to date.
// ----------------------------------------------------------------------------
`default_nettype none

module alrc_ring import alrc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ring_cmd_t  cmd,
  output ring_stat_t stat
);

  logic              active;
  logic              rd_v;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  left;
  ring_op_t          op_r;
  logic [WIN_AW-1:0] addr;
  logic [WIN_AW-1:0] rd_addr;

  logic              ram_we;
  logic [WIN_AW-1:0] ram_waddr;
  logic              ram_wdata;
  logic              ram_re;
  logic              ram_rdata;

  // Reads run one slot ahead of the write-back. Slots of one run are all
  // different, and a new run starts only once the last write is done.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_addr;
    ram_wdata = 1'b0;
    ram_re    = 1'b0;
    if (active) begin
      unique case (op_r)
        RING_CLEAR: begin
          ram_we    = (left != '0);
          ram_waddr = addr;
        end
        RING_AGE, RING_MARK: begin
          ram_re    = (left != '0);
          ram_we    = rd_v;
          ram_wdata = (op_r == RING_MARK);
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  alrc_map_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      rd_v   <= 1'b0;
      count  <= '0;
      left   <= '0;
    end else begin
      rd_v <= ram_re;
      if (cmd.start) begin
        active <= 1'b1;
        left   <= cmd.len;
        if (cmd.op == RING_CLEAR) begin
          count <= '0;
        end
      end else if (active) begin
        if (left != '0) begin
          left <= left - 1'b1;
        end else if (!rd_v) begin
          active <= 1'b0;
        end
        if (rd_v) begin
          if (op_r == RING_AGE && ram_rdata) begin
            count <= count - 1'b1;
          end else if (op_r == RING_MARK && !ram_rdata) begin
            count <= count + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr <= addr;
    if (cmd.start) begin
      op_r <= cmd.op;
      addr <= cmd.addr;
    end else if (active && left != '0) begin
      addr <= (op_r == RING_MARK) ? addr - 1'b1 : addr + 1'b1;
    end
  end

  assign stat.busy  = active;
  assign stat.count = count;

endmodule

`default_nettype wire

>>> rtl/alrc_checker.sv
// ----------------------------------------------------------------------------
// alrc_checker
// Port-level checks of the adaptive latency request controller, attached
// to the top level by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adaptive_latency_request_controller_assert.svh"

module alrc_checker import alrc_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [1:0]         chg;
  logic [BUSY_W-1:0]  busy;
  logic [SWAIT_W-1:0] swait;
  logic [STIME_W-1:0] stime;

  assign chg   = m_axis_tdata[OUT_CHG_LSB +: 2];
  assign busy  = m_axis_tdata[OUT_BUSY_LSB +: BUSY_W];
  assign swait = m_axis_tdata[OUT_WAIT_LSB +: SWAIT_W];
  assign stime = m_axis_tdata[OUT_TIME_LSB +: STIME_W];

  // One word is worked on at a time.
  `ALRC_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")
  // The change code is one of the three defined codes.
  `ALRC_ASSERT_SAME(a_chg_code, m_axis_tvalid, chg == CHG_NONE || chg == CHG_RAISE || chg == CHG_LOWER, "bad change code")
  // A raise or a decrease restarts the samples and empties the ring.
  `ALRC_ASSERT_SAME(a_chg_resets, m_axis_tvalid && chg != CHG_NONE, busy == '0 && swait == '0 && stime == '0, "samples not restarted")
  // The busy count never exceeds the window.
  `ALRC_ASSERT_SAME(a_busy_range, m_axis_tvalid, 32'(busy) <= 32'(WINDOW_MS), "busy count beyond window")
  // A stalled result word holds.
  `ALRC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")

endmodule

bind adaptive_latency_request_controller alrc_checker u_alrc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> verif/tb_adaptive_latency_request_controller.sv
// ----------------------------------------------------------------------------
// Testbench for adaptive_latency_request_controller
// Drives request words (turn ticks, packet wait notes, request loads) over the
// input stream and checks every status word on the output stream against an
// in-bench model of the controller or a status typed into the short table.
// Directed words come first, then random phases with varied registers and idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_adaptive_latency_request_controller;
  import alrc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The selector value that the block is required to ignore.
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int MS_PER_S = 1000;

  localparam int DIR_N          = 23;
  localparam int PHASE_N        = 6;
  localparam int RAND_PER_PHASE = 97;
  localparam int RANDOM_PHASE   = 3;
  localparam int PRESSURE_PHASE = 4;
  localparam int HOLD_CYCLES    = 3000;
  // Allow time for a sweep of the map to finish.
  localparam int DRAIN_CYCLES   = 1100;
  localparam int CYCLE_LIMIT    = 10_000_000;
  localparam int PRINT_CAP      = 100;

  // One input word, fields in the order of the model of the block.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [31:0]       now_ms;
    logic [15:0]       wait_ms;
    logic [31:0]       turn;
    logic              link;
    logic              paused;
    logic              skip;
    logic [3:0]        peers;
    logic [REQ_W-1:0]  new_req;
  } req_word_t;

  // One status word as the block reports it.
  typedef struct packed {
    logic [REQ_W-1:0]   lag_req;
    logic [BUSY_W-1:0]  busy_ms;
    logic [SWAIT_W-1:0] wait_sum;
    logic [STIME_W-1:0] sample_ms;
    chg_t               chg;
  } status_t;

  // A directed row: the word, and where the status is obvious, the status.
  typedef struct packed {
    req_word_t word;
    logic      typed;
    status_t   want;
  } dir_row_t;

  // One full set of register values.
  typedef struct packed {
    logic [PERIOD_W-1:0] direct;
    logic [PERIOD_W-1:0] relay;
    logic [THR_W-1:0]    thr;
    logic [PCT_W-1:0]    pct;
    logic [RATE_W-1:0]   rate;
    logic [REQ_W-1:0]    cap;
  } reg_plan_t;

  // Directed words. The registers hold their reset values here: periods 2000
  // and 4000 ms, threshold 100 ms, 5 percent, 20 turns per second, cap 10.
  localparam dir_row_t DIRECTED_TAB [DIR_N] = '{
    // Tick with the link down right after reset: everything reads zero.
    '{'{FN_TICK, 32'd0, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, 4'd0, 8'd0}, 1'b1,
      '{8'd0, 11'd0, 31'd0, 17'd0, CHG_NONE}},
    // Load the largest request at the top of the timer range.
    '{'{FN_LOAD, 32'hFFFF_FFFF, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, 4'd0, 8'd255}, 1'b1,
      '{8'd255, 11'd0, 31'd0, 17'd0, CHG_NONE}},
    // The unused selector leaves the state alone.
    '{'{FN_UNUSED, 32'd123, 16'd77, 32'd500, 1'b1, 1'b0, 1'b0, 4'd3, 8'd9}, 1'b1,
      '{8'd255, 11'd0, 31'd0, 17'd0, CHG_NONE}},
    // Wait notes are dropped with the link down, while paused, or before turn 50.
    '{'{FN_WAIT, 32'd0, 16'd500, 32'd100, 1'b0, 1'b0, 1'b0, 4'd0, 8'd0}, 1'b1,
      '{8'd255, 11'd0, 31'd0, 17'd0, CHG_NONE}},
    '{'{FN_WAIT, 32'd0, 16'd500, 32'd100, 1'b1, 1'b1, 1'b0, 4'd0, 8'd0}, 1'b1,
      '{8'd255, 11'd0, 31'd0, 17'd0, CHG_NONE}},
    '{'{FN_WAIT, 32'd0, 16'd500, 32'd49, 1'b1, 1'b0, 1'b0, 4'd0, 8'd0}, 1'b1,
      '{8'd255, 11'd0, 31'd0, 17'd0, CHG_NONE}},
    // Largest wait across the timer wrap fills the ring; the request is
    // above the cap, so no raise.
    '{'{FN_WAIT, 32'd0, 16'hFFFF, 32'd50, 1'b1, 1'b0, 1'b0, 4'd0, 8'd0}, 1'b1,
      '{8'd255, 11'd1024, 31'd65535, 17'd0, CHG_NONE}},
    '{'{FN_LOAD, 32'd10, 16'd0, 32'd50, 1'b1, 1'b0, 1'b0, 4'd0, 8'd0}, 1'b1,
      '{8'd0, 11'd0, 31'd0, 17'd0, CHG_NONE}},
    // A full direct period with no waits, but the request is already zero.
    '{'{FN_TICK, 32'd2010, 16'd0, 32'd50, 1'b1, 1'b0, 1'b0, 4'd1, 8'd0}, 1'b1,
      '{8'd0, 11'd0, 31'd0, 17'd0, CHG_NONE}},
    // Raise, a raise blocked by the hold-off, and a raise once it runs out.
    '{'{FN_WAIT, 32'd2020, 16'd150, 32'd60, 1'b1, 1'b0, 1'b0, 4'd0, 8'd0}, 1'b0, '0},
    '{'{FN_WAIT, 32'd2030, 16'd150, 32'd70, 1'b1, 1'b0, 1'b0, 4'd0, 8'd0}, 1'b0, '0},
    '{'{FN_WAIT, 32'd2040, 16'd150, 32'd100, 1'b1, 1'b0, 1'b0, 4'd0, 8'd0}, 1'b0, '0},
    // Ticks that age the ring but take no sample.
    '{'{FN_TICK, 32'd2100, 16'd0, 32'd101, 1'b1, 1'b0, 1'b1, 4'd0, 8'd0}, 1'b0, '0},
    '{'{FN_TICK, 32'd2200, 16'd0, 32'd102, 1'b1, 1'b1, 1'b0, 4'd0, 8'd0}, 1'b0, '0},
    '{'{FN_TICK, 32'd2300, 16'd0, 32'd49, 1'b1, 1'b0, 1'b0, 4'd0, 8'd0}, 1'b0, '0},
    // Relay period selected, then a full relay period with no waits lowers.
    '{'{FN_TICK, 32'd2400, 16'd0, 32'd103, 1'b1, 1'b0, 1'b0, 4'd2, 8'd0}, 1'b0, '0},
    '{'{FN_TICK, 32'd6400, 16'd0, 32'd104, 1'b1, 1'b0, 1'b0, 4'd2, 8'd0}, 1'b0, '0},
    // Tick with the link down reports a zero request.
    '{'{FN_TICK, 32'd6500, 16'd0, 32'd105, 1'b0, 1'b0, 1'b0, 4'd15, 8'd0}, 1'b0, '0},
    // Long gap, clipped sample, turn at its top value; the hold-off wraps.
    '{'{FN_TICK, 32'hFFFF_FF00, 16'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 4'd15, 8'd0},
      1'b0, '0},
    '{'{FN_WAIT, 32'hFFFF_FF10, 16'd1024, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 4'd15, 8'd0},
      1'b0, '0},
    '{'{FN_WAIT, 32'd5, 16'd1, 32'd50, 1'b1, 1'b0, 1'b0, 4'd0, 8'd0}, 1'b0, '0},
    // A loaded request above the cap is kept and blocks raises.
    '{'{FN_LOAD, 32'd100, 16'd0, 32'd0, 1'b0, 1'b0, 1'b0, 4'd0, 8'd200}, 1'b0, '0},
    '{'{FN_WAIT, 32'd110, 16'd300, 32'd60, 1'b1, 1'b0, 1'b0, 4'd0, 8'd0}, 1'b0, '0}
  };

  // Register settings of the random phases. The random phase draws its own.
  localparam reg_plan_t REG_PLAN [PHASE_N] = '{
    '{16'd200,   16'd400,   11'd60,   7'd20,  8'd20,  8'd10},
    '{16'hFFFF,  16'hFFFF,  11'h7FF,  7'h7F,  8'hFF,  8'hFF},
    '{16'd0,     16'd1,     11'd0,    7'd0,   8'd1,   8'd0},
    '{16'd1000,  16'd2000,  11'd80,   7'd10,  8'd30,  8'd20},
    '{16'd100,   16'd300,   11'd1024, 7'd100, 8'd255, 8'd255},
    '{16'd2000,  16'd4000,  11'd100,  7'd5,   8'd20,  8'd10}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [FUNC_W-1:0]     s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  always #1 clk = ~clk;

  adaptive_latency_request_controller u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Controller model: a copy of the registers and of the state of the block.
  // ---------------------------------------------------------------------------
  logic [PERIOD_W-1:0] per_direct, per_relay;
  logic [THR_W-1:0]    thr_busy;
  logic [PCT_W-1:0]    pct_low;
  logic [RATE_W-1:0]   turns_per_s;
  logic [REQ_W-1:0]    req_cap;

  bit                  slot_busy [WINDOW_MS];
  logic [CNT_W-1:0]    busy_slots;
  logic [31:0]         ring_upto_ms;
  logic [31:0]         tick_prev_ms;
  logic [STIME_W-1:0]  sampled_ms;
  logic [SWAIT_W-1:0]  waited_ms;
  logic [REQ_W-1:0]    req_turns;
  logic [31:0]         raise_ok_turn;
  logic [PERIOD_W-1:0] live_period_ms;

  // Status words still owed by the block, oldest first.
  status_t status_due [$];
  int      mismatch_cnt = 0;

  // Idling of both sides, set per phase by the stimulus.
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int phase_no = -1;

  // Simulated game clock of the random words.
  logic [31:0] clock_ms;
  logic [31:0] turn_ctr;

  // Starting a new sample empties the ring and both accumulators.
  function automatic void restart_window(input logic [31:0] now);
    sampled_ms   = '0;
    waited_ms    = '0;
    tick_prev_ms = now;
    busy_slots   = '0;
    foreach (slot_busy[i]) slot_busy[i] = 1'b0;
    ring_upto_ms = now;
  endfunction

  // Clears the slots that have left the window since the last update. A gap
  // of a whole window or more clears the ring outright.
  function automatic void age_ring(input logic [31:0] now);
    logic [31:0]       gap;
    logic [WIN_AW-1:0] ix;
    gap = now - ring_upto_ms;
    if (gap >= WINDOW_MS) begin
      foreach (slot_busy[i]) slot_busy[i] = 1'b0;
      busy_slots = '0;
    end else begin
      for (logic [31:0] k = 1; k <= gap; k++) begin
        ix = WIN_AW'(ring_upto_ms + k);
        if (slot_busy[ix]) begin
          slot_busy[ix] = 1'b0;
          busy_slots = busy_slots - 1'b1;
        end
      end
    end
    ring_upto_ms = now;
  endfunction

  function automatic void model_reset();
    per_direct     = DIRECT_RST;
    per_relay      = RELAY_RST;
    thr_busy       = THR_RST;
    pct_low        = PCT_RST;
    turns_per_s    = RATE_RST;
    req_cap        = MAXREQ_RST;
    restart_window(32'd0);
    req_turns      = '0;
    raise_ok_turn  = '0;
    live_period_ms = DIRECT_RST;
  endfunction

  // Applies one accepted word to the model and returns the status it causes.
  function automatic status_t update_request(input req_word_t w);
    status_t           st;
    chg_t              chg;
    logic [31:0]       span;
    logic [31:0]       wsum;
    logic [63:0]       wait_x;
    logic [63:0]       allow_x;
    int                n;
    logic [WIN_AW-1:0] ix;
    chg = CHG_NONE;
    case (w.func)
      FN_TICK: begin
        if (w.link) begin
          live_period_ms = (w.peers > 4'd1) ? per_relay : per_direct;
          age_ring(w.now_ms);
          if (!w.paused && !w.skip && w.turn >= SAMPLE_START_TURN) begin
            span = w.now_ms - tick_prev_ms;
            if (span > live_period_ms) span = live_period_ms;
            sampled_ms = sampled_ms + span[STIME_W-1:0];
            if (sampled_ms >= live_period_ms) begin
              // Compare the waiting share without a division.
              wait_x  = 64'(waited_ms) * PCT_SCALE;
              allow_x = 64'(pct_low) * 64'(sampled_ms);
              if (wait_x <= allow_x && req_turns != '0) begin
                req_turns     = req_turns - 1'b1;
                raise_ok_turn = '0;
                restart_window(w.now_ms);
                chg = CHG_LOWER;
              end else begin
                sampled_ms = '0;
                waited_ms  = '0;
              end
            end
          end
          tick_prev_ms = w.now_ms;
        end
      end
      FN_WAIT: begin
        if (w.link && !w.paused && w.turn >= SAMPLE_START_TURN) begin
          age_ring(w.now_ms);
          wsum = {1'b0, waited_ms} + w.wait_ms;
          waited_ms = (wsum > WAIT_SAT) ? WAIT_SAT : wsum[SWAIT_W-1:0];
          // Mark the waited milliseconds backwards from now.
          n = (w.wait_ms > WINDOW_MS) ? WINDOW_MS : int'(w.wait_ms);
          for (int k = 0; k < n; k++) begin
            ix = WIN_AW'(w.now_ms - k);
            if (!slot_busy[ix]) begin
              slot_busy[ix] = 1'b1;
              busy_slots = busy_slots + 1'b1;
            end
          end
          if (busy_slots >= thr_busy && req_turns < req_cap && w.turn >= raise_ok_turn) begin
            req_turns     = req_turns + 1'b1;
            raise_ok_turn = w.turn + 32'((64'(live_period_ms) * turns_per_s) / MS_PER_S);
            restart_window(w.now_ms);
            chg = CHG_RAISE;
          end
        end
      end
      FN_LOAD: begin
        restart_window(w.now_ms);
        req_turns     = w.new_req;
        raise_ok_turn = '0;
      end
      default: ;
    endcase
    st.lag_req   = (w.func == FN_TICK && !w.link) ? '0 : req_turns;
    st.busy_ms   = busy_slots;
    st.wait_sum  = waited_ms;
    st.sample_ms = sampled_ms;
    st.chg       = chg;
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_cnt < PRINT_CAP)
      $display("%0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic check_status(input logic [OUT_DATA_W-1:0] d);
    status_t want;
    if (status_due.size() == 0) begin
      report_mismatch("status word with none outstanding", d[31:0], 32'd0);
    end else begin
      want = status_due.pop_front();
      if (d[OUT_REQ_LSB +: REQ_W] !== want.lag_req)
        report_mismatch("lag_request", d[OUT_REQ_LSB +: REQ_W], want.lag_req);
      if (d[OUT_BUSY_LSB +: BUSY_W] !== want.busy_ms)
        report_mismatch("busy_ms", d[OUT_BUSY_LSB +: BUSY_W], want.busy_ms);
      if (d[OUT_WAIT_LSB +: SWAIT_W] !== want.wait_sum)
        report_mismatch("lower_wait_ms", d[OUT_WAIT_LSB +: SWAIT_W], want.wait_sum);
      if (d[OUT_TIME_LSB +: STIME_W] !== want.sample_ms)
        report_mismatch("lower_sample_ms", d[OUT_TIME_LSB +: STIME_W], want.sample_ms);
      if (d[OUT_CHG_LSB +: 2] !== want.chg)
        report_mismatch("change", d[OUT_CHG_LSB +: 2], want.chg);
    end
  endtask

  // Receiver: takes status words and stalls at random. In the pressure phase
  // it first holds off for a long stretch so the block backs up its input.
  int hold_left = 0;
  bit pressure_done = 1'b0;

  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) check_status(m_axis_tdata);
    if (phase_no == PRESSURE_PHASE && !pressure_done) begin
      pressure_done <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  // Watchdog on the whole run.
  int cycle_cnt = 0;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offers one word, optionally after a random gap, and books its status once
  // the block takes it. Valid is only lowered ahead of a gap, so a word that
  // follows directly is offered with valid held high.
  task automatic send_word(input req_word_t w, input status_t want);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= w.func;
    s_axis_tdata  <= {1'b0, w.new_req, w.peers, w.skip, w.paused, w.link,
                      w.turn, w.wait_ms, w.now_ms};
    do @(posedge clk); while (!s_axis_tready);
    status_due.push_back(want);
  endtask

  // Idle means every status word is in and the block takes input again.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (status_due.size() != 0 || !s_axis_tready);
  endtask

  // Cfg_we stays high across back-to-back writes; the caller lowers it.
  task automatic write_reg(input cfg_idx_t ix, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= ix;
    cfg_data  <= val;
    @(posedge clk);
    case (ix)
      CFG_PERIOD_DIRECT: per_direct  = val;
      CFG_PERIOD_RELAY:  per_relay   = val;
      CFG_RAISE_THR:     thr_busy    = val[THR_W-1:0];
      CFG_LOWER_PCT:     pct_low     = val[PCT_W-1:0];
      CFG_TURN_RATE:     turns_per_s = val[RATE_W-1:0];
      CFG_MAX_REQUEST:   req_cap     = val[REQ_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_plan(input reg_plan_t p);
    write_reg(CFG_PERIOD_DIRECT, p.direct);
    write_reg(CFG_PERIOD_RELAY, p.relay);
    write_reg(CFG_RAISE_THR, CFG_W'(p.thr));
    write_reg(CFG_LOWER_PCT, CFG_W'(p.pct));
    write_reg(CFG_TURN_RATE, CFG_W'(p.rate));
    write_reg(CFG_MAX_REQUEST, CFG_W'(p.cap));
    cfg_we <= 1'b0;
  endtask

  // Idling modes: none, sender gaps, receiver stalls, both.
  task automatic set_idling(input int mode);
    case (mode)
      1:       begin snd_idle_pct = 59; rcv_stall_pct = 0;  end
      2:       begin snd_idle_pct = 0;  rcv_stall_pct = 59; end
      3:       begin snd_idle_pct = 38; rcv_stall_pct = 38; end
      default: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
    endcase
  endtask

  // Most random words form a live session: link up, not paused, past the
  // startup turns, with the clock moving a few tens of milliseconds per word.
  // The rest is noise: loads, the unused selector, link down, paused or
  // skipping words, stray turn numbers and long gaps in time.
  function automatic req_word_t next_random_word();
    req_word_t w;
    int        pick;
    clock_ms = clock_ms + $urandom_range(0, 40);
    turn_ctr = turn_ctr + $urandom_range(0, 2);
    w.func    = FN_TICK;
    w.now_ms  = clock_ms;
    w.wait_ms = $urandom_range(0, 150);
    if ($urandom_range(0, 9) == 0) w.wait_ms = $urandom_range(0, 1100);
    if ($urandom_range(0, 39) == 0) w.wait_ms = $urandom_range(0, 65535);
    w.turn    = turn_ctr;
    w.link    = 1'b1;
    w.paused  = 1'b0;
    w.skip    = 1'b0;
    w.peers   = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 1);
    w.new_req = $urandom_range(0, 255);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      w.func = FN_TICK;
    end else if (pick < 85) begin
      w.func = FN_WAIT;
    end else if (pick < 88) begin
      w.func = FN_LOAD;
    end else if (pick < 90) begin
      w.func = FN_UNUSED;
    end else if (pick < 93) begin
      w.func = $urandom_range(0, 1) ? FN_WAIT : FN_TICK;
      w.link = 1'b0;
    end else if (pick < 95) begin
      w.func   = $urandom_range(0, 1) ? FN_WAIT : FN_TICK;
      w.paused = 1'b1;
    end else if (pick < 97) begin
      w.func = FN_TICK;
      w.skip = 1'b1;
    end else if (pick < 98) begin
      w.func = FN_WAIT;
      w.turn = $urandom();
    end else begin
      clock_ms = clock_ms + $urandom_range(1024, 300000);
      w.now_ms = clock_ms;
      w.func   = FN_TICK;
    end
    return w;
  endfunction

  initial begin
    reg_plan_t plan;
    status_t   predicted;
    req_word_t w;

    model_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // The block clears its map after reset before it takes the first word.
    wait_idle();

    // Directed part, registers at their reset values, no idling.
    set_idling(0);
    for (int i = 0; i < DIR_N; i++) begin
      predicted = update_request(DIRECTED_TAB[i].word);
      send_word(DIRECTED_TAB[i].word,
                DIRECTED_TAB[i].typed ? DIRECTED_TAB[i].want : predicted);
    end

    // Random phases, each under its own register setting and an idling mode.
    for (int ph = 0; ph < PHASE_N; ph++) begin
      wait_idle();
      plan = REG_PLAN[ph];
      if (ph == RANDOM_PHASE) begin
        plan.direct = $urandom_range(1, 3000);
        plan.relay  = $urandom_range(1, 6000);
        plan.thr    = $urandom_range(1, 300);
        plan.pct    = $urandom_range(0, 100);
        plan.rate   = $urandom_range(1, 255);
        plan.cap    = $urandom_range(0, 255);
      end
      apply_plan(plan);
      set_idling(ph % 4);
      phase_no = ph;
      clock_ms = $urandom();
      turn_ctr = $urandom_range(50, 100000);
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        w = next_random_word();
        predicted = update_request(w);
        send_word(w, predicted);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
